/* rtl/core/itf_pkg.sv */
// ----------------------------------------------------------------------------
// Integer-to-text formatter package
// Shared codes, character constants, types and the digit lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int unsigned NumDigits = 22;
  localparam int unsigned DigIdxW   = 5;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [1:0] SMODE_NEG   = 2'd0;
  localparam logic [1:0] SMODE_PLUS  = 2'd1;
  localparam logic [1:0] SMODE_SPACE = 2'd2;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [127:0] DIGITS_LO = "0123456789abcdef";
  localparam logic [127:0] DIGITS_UP = "0123456789ABCDEF";

  typedef logic [3:0] nibble_t;

  typedef struct packed {
    logic [1:0]  radix;
    logic [1:0]  sign_mode;
    logic        left_align;
    logic        zero_pad;
    logic        alt_prefix;
    logic        upper_case;
    logic [5:0]  field_width;
    logic [5:0]  min_digits;
    logic [15:0] room;
    logic        neg;
  } itf_req_t;

  typedef struct packed {
    logic               done;
    logic [DigIdxW-1:0] ndig;
  } itf_cstat_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_SCAN
  } conv_state_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_PLAN,
    E_PFX,
    E_SIGN,
    E_LPAD,
    E_ZERO,
    E_DIG,
    E_RPAD,
    E_EMPTY
  } emit_state_t;

  function automatic logic [7:0] digit_char(input nibble_t d, input logic upper);
    logic [127:0] tab;
    tab = upper ? DIGITS_UP : DIGITS_LO;
    return tab[8 * (4'd15 - d) +: 8];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/itf_if.sv */
// ----------------------------------------------------------------------------
// Integer-to-text formatter channels
// Request and character channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  value_size;
  logic        sign_ext;
  logic [1:0]  radix;
  logic [1:0]  sign_mode;
  logic        left_align;
  logic        zero_pad;
  logic        alt_prefix;
  logic        upper_case;
  logic [5:0]  field_width;
  logic [5:0]  min_digits;
  logic [15:0] room;

  modport source (
    output valid, value, value_size, sign_ext, radix, sign_mode, left_align,
           zero_pad, alt_prefix, upper_case, field_width, min_digits, room,
    input  ready
  );
  modport sink (
    input  valid, value, value_size, sign_ext, radix, sign_mode, left_align,
           zero_pad, alt_prefix, upper_case, field_width, min_digits, room,
    output ready
  );
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;
  logic       nothing_written;

  modport source (output valid, character, is_last, nothing_written, input ready);
  modport sink (input valid, character, is_last, nothing_written, output ready);
endinterface

`default_nettype wire

/* rtl/core/integer_to_text_formatter_core.sv */
// ----------------------------------------------------------------------------
// Integer-to-text formatter core
// Formats one integer conversion request into a stream of ASCII characters.
//
// A request beat on in_chan carries the operand and its formatting options.
// The core then sends one character per beat on out_chan, with is_last on
// the final beat; when no character fits in the room, a single beat with
// nothing_written set is sent instead. in_chan.ready is low from the
// accepted request until its last character has entered the output register.
// Decimal operands go through a shift-and-add-three loop over all 64 operand
// bits; octal and hex operands load directly. A scan for the leading digit,
// a planning state and an idle step at each phase change follow, and then
// the characters are sent. A stalled receiver holds the current character in
// the output register and pauses the emitter.
// Reset returns both sequencers to idle and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_formatter_core import itf_pkg::*; #(
  parameter int unsigned MAX_FIELD = 60
) (
  input  logic      clk,
  input  logic      rst_n,
  itf_in_if.sink    in_chan,
  itf_out_if.source out_chan
);

  logic               busy_r, start_r, accept, emit_done;
  itf_req_t           req_r;
  logic [63:0]        mag_r, ext, mag;
  logic               neg;
  itf_cstat_t         cstat;
  logic [DigIdxW-1:0] rd_idx;
  nibble_t            rd_digit;

  assign in_chan.ready = !busy_r;
  assign accept        = in_chan.valid && !busy_r;

  always_comb begin
    unique case (in_chan.value_size)
      SIZE_8:  ext = {{56{in_chan.sign_ext & in_chan.value[7]}}, in_chan.value[7:0]};
      SIZE_16: ext = {{48{in_chan.sign_ext & in_chan.value[15]}}, in_chan.value[15:0]};
      SIZE_32: ext = {{32{in_chan.sign_ext & in_chan.value[31]}}, in_chan.value[31:0]};
      SIZE_64: ext = in_chan.value;
      default: ext = in_chan.value;
    endcase
    neg = in_chan.sign_ext && (in_chan.radix == RADIX_DEC) && ext[63];
    mag = neg ? (64'd0 - ext) : ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (emit_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r             <= mag;
      req_r.radix       <= in_chan.radix;
      req_r.sign_mode   <= in_chan.sign_mode;
      req_r.left_align  <= in_chan.left_align;
      req_r.zero_pad    <= in_chan.zero_pad;
      req_r.alt_prefix  <= in_chan.alt_prefix;
      req_r.upper_case  <= in_chan.upper_case;
      req_r.field_width <= in_chan.field_width;
      req_r.min_digits  <= in_chan.min_digits;
      req_r.room        <= in_chan.room;
      req_r.neg         <= neg;
    end
  end

  itf_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .radix    (req_r.radix),
    .mag      (mag_r),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .stat     (cstat)
  );

  itf_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .cstat    (cstat),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .done     (emit_done),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

/* rtl/core/itf_conv.sv */
// ----------------------------------------------------------------------------
// Digit conversion unit
// Splits the magnitude into digits: a shift-and-add-three loop for decimal,
// a direct load for octal and hex, then a scan for the leading digit.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_conv import itf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         radix,
  input  logic [63:0]        mag,
  input  logic [DigIdxW-1:0] rd_idx,
  output nibble_t            rd_digit,
  output itf_cstat_t         stat
);

  conv_state_t        state_r, state_nxt;
  nibble_t            dig_r [NumDigits];
  nibble_t            dig_nxt [NumDigits];
  nibble_t            adj [NumDigits];
  logic [63:0]        sreg_r, sreg_nxt;
  logic [5:0]         bit_r, bit_nxt;
  logic [DigIdxW-1:0] idx_r, idx_nxt;
  logic [65:0]        mag_o;
  logic [87:0]        mag_h;

  assign mag_o    = {2'b00, mag};
  assign mag_h    = {24'd0, mag};
  assign rd_digit = dig_r[rd_idx];

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    sreg_nxt  = sreg_r;
    bit_nxt   = bit_r;
    idx_nxt   = idx_r;
    stat.done = 1'b0;
    stat.ndig = idx_r + 1'b1;
    for (int k = 0; k < NumDigits; k++) begin
      adj[k] = (dig_r[k] >= 4'd5) ? dig_r[k] + 4'd3 : dig_r[k];
    end
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          if (radix == RADIX_DEC) begin
            for (int k = 0; k < NumDigits; k++) begin
              dig_nxt[k] = '0;
            end
            sreg_nxt  = mag;
            bit_nxt   = '0;
            state_nxt = C_SHIFT;
          end else begin
            for (int k = 0; k < NumDigits; k++) begin
              if (radix == RADIX_OCT) begin
                dig_nxt[k] = {1'b0, mag_o[3*k +: 3]};
              end else begin
                dig_nxt[k] = mag_h[4*k +: 4];
              end
            end
            idx_nxt   = DigIdxW'(NumDigits - 1);
            state_nxt = C_SCAN;
          end
        end
      end
      C_SHIFT: begin
        dig_nxt[0] = {adj[0][2:0], sreg_r[63]};
        for (int k = 1; k < NumDigits; k++) begin
          dig_nxt[k] = {adj[k][2:0], adj[k-1][3]};
        end
        sreg_nxt = {sreg_r[62:0], 1'b0};
        bit_nxt  = bit_r + 6'd1;
        if (bit_r == 6'd63) begin
          idx_nxt   = DigIdxW'(NumDigits - 1);
          state_nxt = C_SCAN;
        end
      end
      C_SCAN: begin
        if (idx_r != '0 && dig_r[idx_r] == 4'd0) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          stat.done = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    sreg_r <= sreg_nxt;
    bit_r  <= bit_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/itf_emit.sv */
// ----------------------------------------------------------------------------
// Character emitter
// Plans the field layout once the digit count is known, then walks the
// prefix, sign, padding, zero and digit phases one character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_emit import itf_pkg::*; #(
  parameter int unsigned MAX_FIELD = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  itf_req_t           req,
  input  itf_cstat_t         cstat,
  output logic [DigIdxW-1:0] rd_idx,
  input  nibble_t            rd_digit,
  output logic               done,
  itf_out_if.source          out_chan
);

  localparam int unsigned CntW    = $clog2(MAX_FIELD + 4);
  localparam int unsigned RoomCap = MAX_FIELD + 3;

  typedef logic [CntW-1:0] cnt_t;

  emit_state_t state_r, state_nxt, next_phase;
  cnt_t        cnt_r, cnt_nxt, next_len;
  cnt_t        total_r, total_nxt;
  cnt_t        pfx_r, lpad_r, zero_r, ndig_r, rpad_r;
  logic        show_r, upper_r;
  logic [7:0]  sign_ch_r;

  cnt_t              w0, p0, r0, w1, w3, ndig_c, need, prec, pad_len, zero_len;
  cnt_t              pfx_len, sum_c, plan_total;
  logic signed [CntW:0] pad_s, pad_a;
  logic              pfx_on, n0, nx, show;
  logic [7:0]        sign_ch;

  logic       slot_free, emit_en, ch_last, ch_nw;
  logic [7:0] ch, phase_ch;
  logic       out_valid_r, out_last_r, out_nw_r;
  logic [7:0] out_char_r;

  // Field layout for the current request.
  always_comb begin
    w0 = (req.field_width > 6'(MAX_FIELD)) ? CntW'(MAX_FIELD) : CntW'(req.field_width);
    p0 = (req.min_digits > 6'(MAX_FIELD)) ? CntW'(MAX_FIELD) : CntW'(req.min_digits);
    r0 = (req.room > 16'(RoomCap)) ? CntW'(RoomCap) : CntW'(req.room);
    w1 = (w0 < r0) ? w0 : r0;
    pfx_on  = req.alt_prefix && (req.radix != RADIX_DEC);
    n0      = pfx_on && (w1 != '0);
    nx      = pfx_on && req.radix[1] && (w1 > CntW'(1));
    pfx_len = CntW'(n0) + CntW'(nx);
    w3      = w1 - pfx_len;
    ndig_c  = CntW'(cstat.ndig);
    need    = (p0 > ndig_c) ? p0 : ndig_c;
    show    = req.neg || (req.sign_mode == SMODE_PLUS) || (req.sign_mode == SMODE_SPACE);
    if (req.neg) begin
      sign_ch = CH_MINUS;
    end else if (req.sign_mode == SMODE_SPACE) begin
      sign_ch = CH_SPACE;
    end else begin
      sign_ch = CH_PLUS;
    end
    if (req.zero_pad) begin
      pad_s = '0;
      prec  = (w3 > p0) ? w3 : p0;
    end else begin
      pad_s = $signed({1'b0, w3}) - $signed({1'b0, need});
      prec  = p0;
    end
    pad_a      = pad_s - $signed({{CntW{1'b0}}, show});
    pad_len    = (pad_a > 0) ? pad_a[CntW-1:0] : '0;
    zero_len   = (prec > ndig_c) ? prec - ndig_c : '0;
    sum_c      = pfx_len + CntW'(show) + pad_len + zero_len + ndig_c;
    plan_total = (sum_c < r0) ? sum_c : r0;
  end

  assign slot_free = !out_valid_r || out_chan.ready;
  assign rd_idx    = DigIdxW'(cnt_r - CntW'(1));

  always_comb begin
    next_phase = E_IDLE;
    next_len   = '0;
    phase_ch   = CH_SPACE;
    unique case (state_r)
      E_PFX: begin
        next_phase = E_SIGN;
        next_len   = CntW'(show_r);
        if (pfx_r == CntW'(2) && cnt_r == CntW'(1)) begin
          phase_ch = upper_r ? CH_X_UP : CH_X_LO;
        end else begin
          phase_ch = CH_ZERO;
        end
      end
      E_SIGN: begin
        next_phase = E_LPAD;
        next_len   = lpad_r;
        phase_ch   = sign_ch_r;
      end
      E_LPAD: begin
        next_phase = E_ZERO;
        next_len   = zero_r;
      end
      E_ZERO: begin
        next_phase = E_DIG;
        next_len   = ndig_r;
        phase_ch   = CH_ZERO;
      end
      E_DIG: begin
        next_phase = E_RPAD;
        next_len   = rpad_r;
        phase_ch   = digit_char(rd_digit, upper_r);
      end
      default: begin
        next_phase = E_IDLE;
        next_len   = '0;
        phase_ch   = CH_SPACE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    emit_en   = 1'b0;
    ch        = phase_ch;
    ch_last   = 1'b0;
    ch_nw     = 1'b0;
    done      = 1'b0;
    unique case (state_r) inside
      E_IDLE: begin
        if (cstat.done) begin
          state_nxt = E_PLAN;
        end
      end
      E_PLAN: begin
        total_nxt = plan_total;
        cnt_nxt   = pfx_len;
        state_nxt = (plan_total == '0) ? E_EMPTY : E_PFX;
      end
      E_EMPTY: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          ch        = CH_NUL;
          ch_last   = 1'b1;
          ch_nw     = 1'b1;
          done      = 1'b1;
          state_nxt = E_IDLE;
        end
      end
      E_PFX, E_SIGN, E_LPAD, E_ZERO, E_DIG, E_RPAD: begin
        if (cnt_r == '0) begin
          state_nxt = next_phase;
          cnt_nxt   = next_len;
        end else if (slot_free) begin
          emit_en   = 1'b1;
          cnt_nxt   = cnt_r - CntW'(1);
          total_nxt = total_r - CntW'(1);
          if (total_r == CntW'(1)) begin
            ch_last   = 1'b1;
            done      = 1'b1;
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (slot_free) begin
        out_valid_r <= emit_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    total_r <= total_nxt;
    if (state_r == E_PLAN) begin
      pfx_r     <= pfx_len;
      show_r    <= show;
      lpad_r    <= req.left_align ? '0 : pad_len;
      rpad_r    <= req.left_align ? pad_len : '0;
      zero_r    <= zero_len;
      ndig_r    <= ndig_c;
      upper_r   <= req.upper_case;
      sign_ch_r <= sign_ch;
    end
    if (emit_en) begin
      out_char_r <= ch;
      out_last_r <= ch_last;
      out_nw_r   <= ch_nw;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.character       = out_char_r;
  assign out_chan.is_last         = out_last_r;
  assign out_chan.nothing_written = out_nw_r;

endmodule

`default_nettype wire
